[hw/rtl/aho_corasick_match_core_defines.svh]
// assertion macros for the aho-corasick match core checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef AHO_CORASICK_MATCH_CORE_DEFINES_SVH
`define AHO_CORASICK_MATCH_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ACM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ACM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/acm_pkg.sv]
// shared types and constants of the aho-corasick match core
// no dependencies
`timescale 1ns / 1ps
package acm_pkg;

  localparam int NODES_DEF    = 4096;
  localparam int ALPHABET_DEF = 26;
  localparam int LETTER_W     = 5;
  localparam int CNT_W        = 16;
  localparam int TOTAL_W      = 32;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_BUILD   = 2'd2,
    MODE_TEXT    = 2'd3
  } acm_mode_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } acm_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] match_total;
    logic               overflow;
  } acm_out_t;

  typedef enum logic {
    ALU_SAT32 = 1'b0,
    ALU_SAT16 = 1'b1
  } acm_alu_op_e;

  typedef struct packed {
    acm_alu_op_e        op;
    logic [TOTAL_W-1:0] a;
    logic [CNT_W-1:0]   b;
  } acm_alu_req_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP,
    S_P_CHK, S_P_NEW, S_P_CRD, S_P_CWR,
    S_B_INIT, S_B_POP, S_B_NOW, S_B_ROW, S_B_SCAN, S_B_TRD, S_B_TCHK, S_B_WR,
    S_T_RD, S_T_CHK, S_T_SRD, S_T_SADD, S_T_FIN
  } acm_state_e;

endpackage

[hw/rtl/acm_ram.sv]
// simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module acm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/acm_alu.sv]
// shared saturating adder for pattern counts and the running total
// depends on acm_pkg
`timescale 1ns / 1ps
module acm_alu (
  input  acm_pkg::acm_alu_req_t          req_i,
  output logic [acm_pkg::TOTAL_W-1:0]    res_o
);
  import acm_pkg::*;

  logic [TOTAL_W:0] sum32;
  logic [CNT_W:0]   sum16;

  assign sum32 = {1'b0, req_i.a} + (TOTAL_W+1)'(req_i.b);
  assign sum16 = {1'b0, req_i.a[CNT_W-1:0]} + {1'b0, req_i.b};

  always_comb begin
    case (req_i.op)
      ALU_SAT32: res_o = sum32[TOTAL_W] ? '1 : sum32[TOTAL_W-1:0];
      ALU_SAT16: res_o = TOTAL_W'(sum16[CNT_W] ? {CNT_W{1'b1}} : sum16[CNT_W-1:0]);
      default:   res_o = '0;
    endcase
  end

endmodule

[hw/rtl/acm_ctrl.sv]
// sequencer, trie memories and walk registers of the match core
// depends on acm_pkg and acm_ram
`timescale 1ns / 1ps
module acm_ctrl #(
  parameter int NODES    = acm_pkg::NODES_DEF,
  parameter int ALPHABET = acm_pkg::ALPHABET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  acm_pkg::acm_in_t              in_item_i,
  output logic                          in_stall_o,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output acm_pkg::acm_out_t             res_o,
  output acm_pkg::acm_alu_req_t         alu_req_o,
  input  logic [acm_pkg::TOTAL_W-1:0]   alu_res_i
);
  import acm_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int RW = ALPHABET * NW;
  localparam int CW = NW + 1;
  localparam logic [NW-1:0] ROOT = NW'(1);

  acm_state_e state_q, state_d;
  acm_in_t    item_q, item_d;

  logic [CW-1:0]       node_count_q, node_count_d;
  logic [NW-1:0]       insert_q, insert_d;
  logic [NW-1:0]       match_q, match_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                full_q, full_d;
  logic                skip_q, skip_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic [NW-1:0]       aux_q, aux_d;
  logic [NW-1:0]       fnow_q, fnow_d;
  logic [RW-1:0]       row_q, row_d;
  logic [LETTER_W-1:0] scan_q, scan_d;
  logic [CW-1:0]       head_q, head_d;
  logic [CW-1:0]       tail_q, tail_d;

  logic          ct_we, ct_re;
  logic [NW-1:0] ct_waddr, ct_raddr;
  logic [RW-1:0] ct_wdata, ct_rd;
  logic          fl_we, fl_re;
  logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rd;
  logic          pc_we, pc_re;
  logic [NW-1:0] pc_waddr, pc_raddr;
  logic [CNT_W-1:0] pc_wdata, pc_rd;
  logic          q_we, q_re;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rd;

  logic                accept;
  logic                in_alpha;
  logic                scan_end;
  logic [LETTER_W-1:0] fld_sel;
  logic [NW-1:0]       ct_fld;
  logic [NW-1:0]       scan_fld;
  logic [CW-1:0]       nc_inc;
  logic                room;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign in_alpha = item_q.letter < LETTER_W'(ALPHABET);
  assign scan_end = scan_q == LETTER_W'(ALPHABET - 1);
  assign fld_sel  = (state_q == S_B_TCHK) ? scan_q : item_q.letter;
  assign ct_fld   = ct_rd[fld_sel*NW +: NW];
  assign scan_fld = row_q[scan_q*NW +: NW];
  assign nc_inc   = node_count_q + CW'(1);
  assign room     = nc_inc < CW'(NODES);

  assign in_stall_o = state_q != S_IDLE;

  acm_ram #(.WIDTH(RW), .DEPTH(NODES)) u_child (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .re_i(ct_re), .raddr_i(ct_raddr), .rdata_o(ct_rd)
  );

  acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .re_i(fl_re), .raddr_i(fl_raddr), .rdata_o(fl_rd)
  );

  acm_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count (
    .clk_i, .we_i(pc_we), .waddr_i(pc_waddr), .wdata_i(pc_wdata),
    .re_i(pc_re), .raddr_i(pc_raddr), .rdata_o(pc_rd)
  );

  acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: if (accept) state_d = S_DISP;
      S_DISP: begin
        case (item_q.mode)
          MODE_CLEAR:   state_d = S_INIT;
          MODE_PATTERN: state_d = (skip_q || !in_alpha) ? S_IDLE : S_P_CHK;
          MODE_BUILD:   state_d = S_B_INIT;
          MODE_TEXT:    state_d = in_alpha ? S_T_RD : S_T_FIN;
          default:      state_d = S_IDLE;
        endcase
      end
      S_P_CHK: begin
        if (ct_fld != '0) begin
          state_d = item_q.last ? S_P_CRD : S_IDLE;
        end else if (room) begin
          state_d = S_P_NEW;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_P_NEW:  state_d = item_q.last ? S_P_CRD : S_IDLE;
      S_P_CRD:  state_d = S_P_CWR;
      S_P_CWR:  state_d = S_IDLE;
      S_B_INIT: state_d = S_B_POP;
      S_B_POP: begin
        if (head_q == tail_q || head_q >= CW'(NODES)) state_d = S_IDLE;
        else state_d = S_B_NOW;
      end
      S_B_NOW: state_d = S_B_ROW;
      S_B_ROW: state_d = S_B_SCAN;
      S_B_SCAN: begin
        if (scan_fld != '0) state_d = S_B_TRD;
        else if (scan_end) state_d = S_B_POP;
      end
      S_B_TRD:  state_d = (cur_q == '0) ? S_B_WR : S_B_TCHK;
      S_B_TCHK: state_d = (ct_fld != '0) ? S_B_WR : S_B_TRD;
      S_B_WR:   state_d = scan_end ? S_B_POP : S_B_SCAN;
      S_T_RD:   state_d = (cur_q == '0) ? S_T_SRD : S_T_CHK;
      S_T_CHK:  state_d = (ct_fld != '0) ? S_T_SRD : S_T_RD;
      S_T_SRD:  state_d = (cur_q == '0) ? S_T_FIN : S_T_SADD;
      S_T_SADD: state_d = S_T_SRD;
      S_T_FIN: begin
        if (!item_q.last || res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs, memory ports and register updates
  always_comb begin
    item_d       = item_q;
    node_count_d = node_count_q;
    insert_d     = insert_q;
    match_d      = match_q;
    total_d      = total_q;
    full_d       = full_q;
    skip_d       = skip_q;
    cur_d        = cur_q;
    aux_d        = aux_q;
    fnow_d       = fnow_q;
    row_d        = row_q;
    scan_d       = scan_q;
    head_d       = head_q;
    tail_d       = tail_q;

    ct_we = 1'b0; ct_waddr = cur_q; ct_wdata = '0; ct_re = 1'b0; ct_raddr = cur_q;
    fl_we = 1'b0; fl_waddr = cur_q; fl_wdata = '0; fl_re = 1'b0; fl_raddr = cur_q;
    pc_we = 1'b0; pc_waddr = cur_q; pc_wdata = '0; pc_re = 1'b0; pc_raddr = cur_q;
    q_we  = 1'b0; q_waddr  = tail_q[NW-1:0]; q_wdata = aux_q;
    q_re  = 1'b0; q_raddr  = head_q[NW-1:0];

    alu_req_o.op = ALU_SAT32;
    alu_req_o.a  = total_q;
    alu_req_o.b  = '0;

    res_valid_o       = 1'b0;
    res_o.match_total = total_q;
    res_o.overflow    = full_q;

    case (state_q)
      S_INIT: begin
        ct_we = 1'b1; ct_waddr = ROOT;
        fl_we = 1'b1; fl_waddr = ROOT;
        pc_we = 1'b1; pc_waddr = ROOT;
        node_count_d = CW'(1);
        insert_d     = ROOT;
        match_d      = ROOT;
        total_d      = '0;
        full_d       = 1'b0;
        skip_d       = 1'b0;
      end
      S_IDLE: begin
        if (accept) item_d = in_item_i;
      end
      S_DISP: begin
        case (item_q.mode)
          MODE_PATTERN: begin
            if (skip_q || !in_alpha) begin
              skip_d = !item_q.last;
              if (item_q.last) insert_d = ROOT;
            end else begin
              ct_re = 1'b1; ct_raddr = insert_q;
            end
          end
          MODE_TEXT: begin
            if (in_alpha) cur_d = match_q;
            else match_d = ROOT;
          end
          default: ;
        endcase
      end
      S_P_CHK: begin
        if (ct_fld != '0) begin
          insert_d = ct_fld;
          cur_d    = ct_fld;
        end else if (room) begin
          node_count_d = nc_inc;
          ct_we    = 1'b1;
          ct_waddr = insert_q;
          ct_wdata = ct_rd;
          ct_wdata[item_q.letter*NW +: NW] = nc_inc[NW-1:0];
          insert_d = nc_inc[NW-1:0];
          cur_d    = nc_inc[NW-1:0];
        end else begin
          full_d = 1'b1;
          skip_d = !item_q.last;
          if (item_q.last) insert_d = ROOT;
        end
      end
      S_P_NEW: begin
        ct_we = 1'b1;
        fl_we = 1'b1;
        pc_we = 1'b1;
      end
      S_P_CRD: pc_re = 1'b1;
      S_P_CWR: begin
        alu_req_o.op = ALU_SAT16;
        alu_req_o.a  = TOTAL_W'(pc_rd);
        alu_req_o.b  = CNT_W'(1);
        pc_we    = 1'b1;
        pc_wdata = alu_res_i[CNT_W-1:0];
        insert_d = ROOT;
      end
      S_B_INIT: begin
        q_we = 1'b1; q_waddr = '0; q_wdata = ROOT;
        fl_we = 1'b1; fl_waddr = ROOT;
        head_d = '0;
        tail_d = CW'(1);
      end
      S_B_POP: begin
        if (!(head_q == tail_q || head_q >= CW'(NODES))) begin
          q_re   = 1'b1;
          head_d = head_q + CW'(1);
        end
      end
      S_B_NOW: begin
        ct_re = 1'b1; ct_raddr = q_rd;
        fl_re = 1'b1; fl_raddr = q_rd;
      end
      S_B_ROW: begin
        row_d  = ct_rd;
        fnow_d = fl_rd;
        scan_d = '0;
      end
      S_B_SCAN: begin
        if (scan_fld != '0) begin
          aux_d = scan_fld;
          cur_d = fnow_q;
        end else if (!scan_end) begin
          scan_d = scan_q + LETTER_W'(1);
        end
      end
      S_B_TRD: begin
        if (cur_q == '0) begin
          cur_d = ROOT;
        end else begin
          ct_re = 1'b1;
          fl_re = 1'b1;
        end
      end
      S_B_TCHK: cur_d = (ct_fld != '0) ? ct_fld : fl_rd;
      S_B_WR: begin
        fl_we = 1'b1; fl_waddr = aux_q; fl_wdata = cur_q;
        if (tail_q < CW'(NODES)) begin
          q_we   = 1'b1;
          tail_d = tail_q + CW'(1);
        end
        if (!scan_end) scan_d = scan_q + LETTER_W'(1);
      end
      S_T_RD: begin
        if (cur_q == '0) begin
          match_d = ROOT;
          cur_d   = ROOT;
        end else begin
          ct_re = 1'b1;
          fl_re = 1'b1;
        end
      end
      S_T_CHK: begin
        if (ct_fld != '0) begin
          match_d = ct_fld;
          cur_d   = ct_fld;
        end else begin
          cur_d = fl_rd;
        end
      end
      S_T_SRD: begin
        if (cur_q != '0) begin
          pc_re = 1'b1;
          fl_re = 1'b1;
        end
      end
      S_T_SADD: begin
        alu_req_o.op = ALU_SAT32;
        alu_req_o.a  = total_q;
        alu_req_o.b  = pc_rd;
        total_d = alu_res_i;
        cur_d   = fl_rd;
      end
      S_T_FIN: begin
        if (item_q.last && res_ready_i) begin
          res_valid_o = 1'b1;
          total_d     = '0;
          match_d     = ROOT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      node_count_q <= CW'(1);
      insert_q     <= ROOT;
      match_q      <= ROOT;
      total_q      <= '0;
      full_q       <= 1'b0;
      skip_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      scan_q       <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      insert_q     <= insert_d;
      match_q      <= match_d;
      total_q      <= total_d;
      full_q       <= full_d;
      skip_q       <= skip_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      scan_q       <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    aux_q  <= aux_d;
    fnow_q <= fnow_d;
    row_q  <= row_d;
  end

endmodule

[hw/rtl/aho_corasick_match_core.sv]
// Aho-Corasick multi-pattern match core. Items are taken one at a time; the
// sequencer owns four single-port-pair memories (child rows of ALPHABET node
// indexes, failure links, pattern counts, walk queue) and a shared saturating
// adder, each memory read being registered. Clear rewrites only the root;
// nodes are zeroed as they are created, so there is no clearing pass, also
// not after reset. A pattern letter reads the child row, adds a node if it
// is missing and there is room, and on the last letter reads and bumps the
// pattern count. A text letter follows failure links until a child is found,
// then adds the counts of every node on the suffix chain; a text letter
// outside the alphabet sends the walk back to the root without adding counts.
// Building walks the trie breadth first through the queue. The total
// is held in an output register, so the next item can be taken while a
// result still waits; a last text letter only waits while that register is
// full and stalled.
// depends on acm_pkg, acm_ctrl, acm_alu
`timescale 1ns / 1ps
module aho_corasick_match_core #(
  parameter int NODES    = acm_pkg::NODES_DEF,
  parameter int ALPHABET = acm_pkg::ALPHABET_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  acm_pkg::acm_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acm_pkg::acm_out_t out_item_o
);
  import acm_pkg::*;

  logic                res_ready;
  logic                res_valid;
  acm_out_t            res;
  acm_alu_req_t        alu_req;
  logic [TOTAL_W-1:0]  alu_res;
  logic                out_valid_q;
  acm_out_t            out_item_q;

  assign res_ready = !out_valid_q || !out_stall_i;

  acm_ctrl #(.NODES(NODES), .ALPHABET(ALPHABET)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_item_i,
    .in_stall_o,
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res)
  );

  acm_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/acm_match_chk.sv]
// port-level checker for the match core, bound to the top level
// depends on acm_pkg and aho_corasick_match_core_defines.svh
`timescale 1ns / 1ps
`include "aho_corasick_match_core_defines.svh"
module acm_match_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input acm_pkg::acm_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input acm_pkg::acm_out_t out_item_o
);
  import acm_pkg::*;

  // an accepted item keeps the core busy in the next cycle
  `ACM_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of work on an item
  `ACM_ASSERT_IMPL(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  `ACM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  `ACM_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i))

endmodule

bind aho_corasick_match_core acm_match_chk u_chk (.*);

[dv/tb_top.sv]
// self-checking testbench of the aho-corasick match core
// predicts match totals with its own trie model and checks every result transfer
// depends on acm_pkg and aho_corasick_match_core
`timescale 1ns / 1ps
module tb_top;
  import acm_pkg::*;

  localparam int N_NODES = NODES_DEF;
  localparam int N_ALPHA = ALPHABET_DEF;
  localparam int ROOT_ND = 1;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  acm_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  acm_out_t out_item_o;

  aho_corasick_match_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // trie model
  int unsigned child_q[N_NODES][N_ALPHA];
  int unsigned fail_q[N_NODES];
  int unsigned cnt_q[N_NODES];
  int unsigned walk_q[N_NODES];
  int unsigned n_used, ins_nd, txt_nd;
  int unsigned total_q;
  bit          full_q, skip_q;

  acm_in_t     item_q[$];
  acm_out_t    total_exp_q[$];
  int          n_err = 0;
  int          n_res = 0;
  int          send_idle = 12;
  int          recv_idle = 88;
  int          hold_cnt = 0;
  bit          hold_req = 1'b0;
  bit          in_fire = 1'b0;

  function automatic int unsigned nd_ok(int unsigned v);
    return (v < N_NODES) ? v : 0;
  endfunction

  function automatic int unsigned kid(int unsigned nd, int unsigned c);
    return nd_ok(child_q[nd_ok(nd)][c]);
  endfunction

  function automatic void trie_clear();
    foreach (child_q[i, j]) child_q[i][j] = 0;
    foreach (fail_q[i]) begin
      fail_q[i] = 0;
      cnt_q[i] = 0;
    end
    for (int c = 0; c < N_ALPHA; c++) child_q[0][c] = ROOT_ND;
    n_used = ROOT_ND;
    ins_nd = ROOT_ND;
    txt_nd = ROOT_ND;
    total_q = 0;
    full_q = 0;
    skip_q = 0;
  endfunction

  function automatic void trie_add(int unsigned c, bit lst);
    int unsigned nx;
    if (!skip_q) begin
      if (c >= N_ALPHA) skip_q = 1;
      else begin
        nx = kid(ins_nd, c);
        if (nx == 0) begin
          if (n_used + 1 < N_NODES) begin
            n_used++;
            nx = n_used;
            child_q[nd_ok(ins_nd)][c] = nx;
          end else begin
            full_q = 1;
            skip_q = 1;
          end
        end
        if (!skip_q) ins_nd = nx;
      end
    end
    if (lst) begin
      if (!skip_q && cnt_q[nd_ok(ins_nd)] < 16'hFFFF) cnt_q[nd_ok(ins_nd)]++;
      skip_q = 0;
      ins_nd = ROOT_ND;
    end
  endfunction

  function automatic void link_build();
    int unsigned hd, tl, nw, ch, t, g;
    hd = 0;
    tl = 1;
    walk_q[0] = ROOT_ND;
    fail_q[ROOT_ND] = 0;
    while (hd != tl && hd < N_NODES) begin
      nw = nd_ok(walk_q[hd]);
      hd++;
      for (int c = 0; c < N_ALPHA; c++) begin
        ch = kid(nw, c);
        if (ch != 0) begin
          t = nd_ok(fail_q[nw]);
          for (g = 0; g < N_NODES && kid(t, c) == 0; g++) t = nd_ok(fail_q[t]);
          fail_q[ch] = kid(t, c);
          if (tl < N_NODES) walk_q[tl++] = ch;
        end
      end
    end
  endfunction

  function automatic void text_step(int unsigned c);
    int unsigned nw, g, j;
    longint unsigned sum;
    sum = 0;
    nw = nd_ok(txt_nd);
    if (c >= N_ALPHA) begin
      txt_nd = ROOT_ND;
      return;
    end
    for (g = 0; g < N_NODES && kid(nw, c) == 0; g++) nw = nd_ok(fail_q[nw]);
    nw = kid(nw, c);
    if (nw == 0) nw = ROOT_ND;
    txt_nd = nw;
    j = nw;
    for (g = 0; g < N_NODES && j != 0; g++) begin
      sum += cnt_q[j];
      j = nd_ok(fail_q[j]);
    end
    sum += total_q;
    total_q = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void predict_total(acm_in_t it);
    acm_out_t r;
    case (acm_mode_e'(it.mode))
      MODE_CLEAR:   trie_clear();
      MODE_PATTERN: trie_add(it.letter, it.last);
      MODE_BUILD:   link_build();
      default: begin
        text_step(it.letter);
        if (it.last) begin
          r.match_total = total_q;
          r.overflow = full_q;
          total_exp_q.push_back(r);
          total_q = 0;
          txt_nd = ROOT_ND;
        end
      end
    endcase
  endfunction

  function automatic acm_in_t mk(acm_mode_e m, int unsigned l, bit lst);
    acm_in_t it;
    it.mode = m;
    it.letter = LETTER_W'(l);
    it.last = lst;
    return it;
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        predict_total(in_item_i);
      end
      if (!in_valid_i || in_fire) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_item_i <= item_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          if ($urandom_range(1)) in_item_i <= acm_in_t'(8'($urandom));
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 400;
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor, model update happens at negedge so compare against queue here
  always @(posedge clk_i) begin
    acm_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_res++;
      if (total_exp_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result total=%0d ovf=%0b", $time,
                 out_item_o.match_total, out_item_o.overflow);
      end else begin
        e = total_exp_q.pop_front();
        if (e.match_total !== out_item_o.match_total) begin
          n_err++;
          $display("%0t: match_total expected %0d actual %0d", $time,
                   e.match_total, out_item_o.match_total);
        end
        if (e.overflow !== out_item_o.overflow) begin
          n_err++;
          $display("%0t: overflow expected %0b actual %0b", $time,
                   e.overflow, out_item_o.overflow);
        end
      end
    end
  end

  task automatic add_word(int unsigned len, int unsigned span);
    for (int i = 0; i < len; i++)
      item_q.push_back(mk(MODE_PATTERN, $urandom_range(span - 1), i == len - 1));
  endtask

  task automatic add_text(int unsigned len, int unsigned span);
    for (int i = 0; i < len; i++)
      item_q.push_back(mk(MODE_TEXT, $urandom_range(span - 1), i == len - 1));
  endtask

  task automatic drain();
    while (item_q.size() > 0 || in_valid_i || total_exp_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  int unsigned span;

  initial begin
    trie_clear();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: edge letters, skipped patterns, text before build, build, clear
    item_q.push_back(mk(MODE_PATTERN, 0, 0));
    item_q.push_back(mk(MODE_PATTERN, 25, 1));
    item_q.push_back(mk(MODE_PATTERN, 31, 0));
    item_q.push_back(mk(MODE_PATTERN, 2, 1));
    item_q.push_back(mk(MODE_PATTERN, 25, 1));
    item_q.push_back(mk(MODE_TEXT, 0, 0));
    item_q.push_back(mk(MODE_TEXT, 25, 1));
    item_q.push_back(mk(MODE_BUILD, 0, 0));
    item_q.push_back(mk(MODE_TEXT, 25, 0));
    item_q.push_back(mk(MODE_TEXT, 30, 0));
    item_q.push_back(mk(MODE_TEXT, 0, 0));
    item_q.push_back(mk(MODE_TEXT, 25, 1));
    item_q.push_back(mk(MODE_TEXT, 26, 1));
    item_q.push_back(mk(MODE_PATTERN, 0, 1));
    item_q.push_back(mk(MODE_TEXT, 0, 1));
    item_q.push_back(mk(MODE_BUILD, 0, 1));
    item_q.push_back(mk(MODE_TEXT, 0, 1));
    item_q.push_back(mk(MODE_CLEAR, 31, 1));
    item_q.push_back(mk(MODE_TEXT, 0, 1));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 88 : 0;
      recv_idle = (ph == 0) ? 88 : (ph == 1) ? 12 : 0;
      for (int g = 0; g < 11; g++) begin
        span = (g % 3 == 0) ? 2 : (g % 3 == 1) ? 4 : 26;
        item_q.push_back(mk(MODE_CLEAR, $urandom_range(31), $urandom_range(1)));
        for (int p = 0; p < 4; p++) add_word($urandom_range(1, 4), span);
        if ($urandom_range(3) == 0) item_q.push_back(mk(MODE_PATTERN, 31, 1));
        item_q.push_back(mk(MODE_BUILD, $urandom_range(31), $urandom_range(1)));
        for (int t = 0; t < 3; t++) add_text($urandom_range(1, 8), span);
        if ($urandom_range(4) == 0) item_q.push_back(acm_in_t'(8'($urandom)));
      end
      if (ph == 2) begin
        for (int k = 0; k < 20; k++) add_text(2, 2);
        hold_req = 1'b1;
        wait (hold_cnt > 0);
        hold_req = 1'b0;
      end
      drain();
    end

    $display("covered clear, pattern, build and text items under three idle mixes");
    $display("and a long receiver hold-off; %0d results checked", n_res);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
